[hw/rtl/bank_switch_irq_mapper_macros.svh]
// assertion macros shared by the mapper checker
`ifndef BANK_SWITCH_IRQ_MAPPER_MACROS_SVH
`define BANK_SWITCH_IRQ_MAPPER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BSIM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bsim_pkg.sv]
// types, constants and the mirroring table of the bank switch irq mapper
package bsim_pkg;

    localparam int BankBitsDefault = 8;

    localparam int AddrW  = 16;
    localparam int DataW  = 8;
    localparam int CycW   = 8;
    localparam int OffW   = 22;
    localparam int CntW   = 16;
    localparam int NtW    = 4;
    localparam int NumPat = 8;

    typedef enum logic [1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_PAT_XLATE = 2'd2,
        FUNC_PRG_XLATE = 2'd3
    } t_func;

    // register select, low address nibble (0-7 are the pattern banks)
    localparam logic [3:0] REG_PRG_BANK = 4'h8;
    localparam logic [3:0] REG_MIRROR   = 4'h9;
    localparam logic [3:0] REG_IRQ_CTRL = 4'hA;
    localparam logic [3:0] REG_LATCH_LO = 4'hB;
    localparam logic [3:0] REG_LATCH_HI = 4'hC;

    localparam logic [AddrW-1:0] REG_BASE   = 16'h6000;
    localparam logic [AddrW-1:0] PAT_LIMIT  = 16'h2000;
    localparam logic [AddrW-1:0] PRG_WIN_LO = 16'h8000;
    localparam logic [AddrW-1:0] PRG_WIN_HI = 16'hBFFF;
    localparam logic [CntW-1:0]  CNT_WRAP   = 16'hFFFF;

    // mirroring mode to nametable map
    function automatic logic [NtW-1:0] nt_map(input logic [1:0] mode);
        logic [NtW-1:0] map;
        case (mode)
            2'd0: begin
                map = 4'hA;
            end
            2'd1: begin
                map = 4'hC;
            end
            2'd2: begin
                map = 4'h0;
            end
            default: begin
                map = 4'hF;
            end
        endcase
        return map;
    endfunction

endpackage

[hw/rtl/bank_switch_irq_mapper.sv]
// bank switch mapper with cycle down-counter irq, top level
// Each request is captured in an input register, decoded, applied to the mapper state and
// translated by short logic, and the result is loaded into an output register once that
// register is free. A new request is taken every cycle while o_in_stall is low;
// o_in_stall rises only while the input register holds a request and the output
// register is full and stalled. func 0 is a bus write (ignored below 0x6000, decoded by
// the low address nibble), func 1 advances the irq down-counter by elapsed_cycles while
// enabled, func 2 translates a pattern address below 0x2000 through the 1 KB banks and
// func 3 translates a program address in 0x8000-0xBFFF through the 16 KB bank. Every
// result carries the irq level, enable, counter and nametable map after the request.
module bank_switch_irq_mapper
    import bsim_pkg::*;
#(
    parameter int BANK_BITS = BankBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [AddrW-1:0]     i_address,
    input  logic [DataW-1:0]     i_write_data,
    input  logic [CycW-1:0]      i_elapsed_cycles,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_irq_line,
    output logic                 o_irq_enabled,
    output logic [OffW-1:0]      o_rom_offset,
    output logic                 o_window_hit,
    output logic [NtW-1:0]       o_nametable_map,
    output logic [CntW-1:0]      o_counter_value
);

    // input register
    logic              r_in_valid;
    t_func             r_func;
    logic [AddrW-1:0]  r_address;
    logic [DataW-1:0]  r_write_data;
    logic [CycW-1:0]   r_cycles;

    // mapper state; only the low BANK_BITS of a bank number are ever used, so only
    // those are kept
    logic [BANK_BITS-1:0] r_pat_bank [NumPat];
    logic [BANK_BITS-1:0] n_pat_bank [NumPat];
    logic [BANK_BITS-1:0] r_prg_bank, n_prg_bank;
    logic [1:0]           r_mirror, n_mirror;
    logic [CntW-1:0]      r_reload, n_reload;
    logic [CntW-1:0]      r_counter, n_counter;
    logic                 r_cnt_en, n_cnt_en;
    logic                 r_irq, n_irq;

    // output register
    logic              r_out_valid;
    logic [OffW-1:0]   r_offset, n_offset;
    logic              r_hit, n_hit;

    logic out_free;
    logic advance;
    logic in_take;

    // the output register can load when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
        // payload loads only with a request, so a held request never changes
        if (in_take && i_in_valid) begin
            r_func       <= t_func'(i_func);
            r_address    <= i_address;
            r_write_data <= i_write_data;
            r_cycles     <= i_elapsed_cycles;
        end
    end

    // decode, state update and translation
    always_comb begin
        logic [3:0] nib;
        logic [2:0] pat_sel;
        n_pat_bank = r_pat_bank;
        n_prg_bank = r_prg_bank;
        n_mirror   = r_mirror;
        n_reload   = r_reload;
        n_counter  = r_counter;
        n_cnt_en   = r_cnt_en;
        n_irq      = r_irq;
        n_offset   = '0;
        n_hit      = 1'b0;
        nib        = r_address[3:0];
        pat_sel    = r_address[12:10];
        case (r_func)
            FUNC_WRITE: begin
                if (r_address >= REG_BASE) begin
                    if (!nib[3]) begin
                        n_pat_bank[nib[2:0]] = r_write_data[BANK_BITS-1:0];
                    end else begin
                        case (nib)
                            REG_PRG_BANK: begin
                                n_prg_bank = r_write_data[BANK_BITS-1:0];
                            end
                            REG_MIRROR: begin
                                n_mirror = r_write_data[1:0];
                            end
                            REG_IRQ_CTRL: begin
                                n_irq     = 1'b0;
                                n_cnt_en  = r_write_data[0];
                                n_counter = r_reload;
                            end
                            REG_LATCH_LO: begin
                                n_reload = {r_reload[CntW-1:DataW], r_write_data};
                            end
                            REG_LATCH_HI: begin
                                n_reload = {r_write_data, r_reload[DataW-1:0]};
                            end
                            default: begin
                                n_reload = r_reload;
                            end
                        endcase
                    end
                end
            end
            FUNC_TICK: begin
                if (r_cnt_en) begin
                    if (CntW'(r_cycles) > r_counter) begin
                        // underflow: park at all ones, stop and raise the line
                        n_counter = CNT_WRAP;
                        n_cnt_en  = 1'b0;
                        n_irq     = 1'b1;
                    end else begin
                        n_counter = r_counter - CntW'(r_cycles);
                    end
                end
            end
            FUNC_PAT_XLATE: begin
                if (r_address < PAT_LIMIT) begin
                    n_offset = (OffW'(r_pat_bank[pat_sel]) << 10) | OffW'(r_address[9:0]);
                    n_hit    = 1'b1;
                end
            end
            default: begin
                if (r_address >= PRG_WIN_LO && r_address <= PRG_WIN_HI) begin
                    n_offset = (OffW'(r_prg_bank) << 14) | OffW'(r_address[13:0]);
                    n_hit    = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumPat; i++) begin
                r_pat_bank[i] <= '0;
            end
            r_prg_bank  <= '0;
            r_mirror    <= '0;
            r_reload    <= '0;
            r_counter   <= '0;
            r_cnt_en    <= 1'b0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_pat_bank <= n_pat_bank;
                r_prg_bank <= n_prg_bank;
                r_mirror   <= n_mirror;
                r_reload   <= n_reload;
                r_counter  <= n_counter;
                r_cnt_en   <= n_cnt_en;
                r_irq      <= n_irq;
            end
            if (out_free) begin
                r_out_valid <= advance;
            end
        end
    end

    // translation payload; state fields are read straight from the state registers,
    // which change only together with a new result
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_offset <= n_offset;
            r_hit    <= n_hit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_irq_line      = r_irq;
    assign o_irq_enabled   = r_cnt_en;
    assign o_rom_offset    = r_offset;
    assign o_window_hit    = r_hit;
    assign o_nametable_map = nt_map(r_mirror);
    assign o_counter_value = r_counter;

endmodule

[hw/rtl/bsim_checker.sv]
// port-level checker for the bank switch irq mapper, with its bind
`include "bank_switch_irq_mapper_macros.svh"

module bsim_checker
    import bsim_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_func,
    input logic [AddrW-1:0]  i_address,
    input logic [DataW-1:0]  i_write_data,
    input logic [CycW-1:0]   i_elapsed_cycles,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_irq_line,
    input logic              o_irq_enabled,
    input logic [OffW-1:0]   o_rom_offset,
    input logic              o_window_hit,
    input logic [NtW-1:0]    o_nametable_map,
    input logic [CntW-1:0]   o_counter_value
);

    // a stalled request holds
    `BSIM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_func) && $stable(i_address) && $stable(i_write_data) && $stable(i_elapsed_cycles),
        "stalled request changed")

    // a stalled result holds
    `BSIM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_rom_offset) && $stable(o_counter_value) && $stable(o_irq_line) && $stable(o_irq_enabled) && $stable(o_window_hit) && $stable(o_nametable_map),
        "stalled result changed")

    // underflow stops the counter, a reload clears the line: never both set
    `BSIM_ASSERT_NOW(a_irq_vs_en, i_clk, i_rst_n, o_out_valid,
        !(o_irq_line && o_irq_enabled), "irq raised while counter enabled")

    // a raised line means the counter is parked at all ones
    `BSIM_ASSERT_NOW(a_irq_wrap, i_clk, i_rst_n, o_out_valid && o_irq_line,
        o_counter_value == CNT_WRAP, "irq raised but counter not wrapped")

    // a miss or a non-translate result carries no offset
    `BSIM_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_window_hit,
        o_rom_offset == '0, "offset set without a window hit")

endmodule

bind bank_switch_irq_mapper bsim_checker u_bsim_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the bank switch irq mapper: directed and random requests
`timescale 1ns / 1ps

module testbench;
    import bsim_pkg::*;

    // ---------------------------------------------------------------------------------
    // local codes and limits
    // ---------------------------------------------------------------------------------
    // pattern bank registers sit at nibbles 0 through this one
    localparam logic [3:0] REG_PAT_LAST = 4'h7;
    // nibbles from here up decode to nothing
    localparam logic [3:0] REG_NOP_FIRST = 4'hD;
    localparam logic [DataW-1:0] BankMask = DataW'((1 << BankBitsDefault) - 1);
    // the result register sits right behind the input register, so this drain window is plenty
    localparam int DrainCycles = 8;
    // no acceptance on either side for this long means the block hung; even an 88 percent
    // stall or gap practically never runs this long, so this is a wide margin
    localparam int HangLimit = 2000;

    typedef enum logic [1:0] {
        MIRROR_VERT  = 2'd0,
        MIRROR_HORZ  = 2'd1,
        MIRROR_ONE_A = 2'd2,
        MIRROR_ONE_B = 2'd3
    } t_mirror;

    // one result of the mapper, in port order
    typedef struct packed {
        logic              irq;
        logic              enabled;
        logic [OffW-1:0]   offset;
        logic              hit;
        logic [NtW-1:0]    nt_map;
        logic [CntW-1:0]   counter;
    } t_mapper_out;

    // ---------------------------------------------------------------------------------
    // dut hookup, every input known from time zero
    // ---------------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = '0;
    logic [AddrW-1:0]   i_address = '0;
    logic [DataW-1:0]   i_write_data = '0;
    logic [CycW-1:0]    i_elapsed_cycles = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_irq_line;
    logic               o_irq_enabled;
    logic [OffW-1:0]    o_rom_offset;
    logic               o_window_hit;
    logic [NtW-1:0]     o_nametable_map;
    logic [CntW-1:0]    o_counter_value;

    bank_switch_irq_mapper dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_elapsed_cycles (i_elapsed_cycles),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_irq_line       (o_irq_line),
        .o_irq_enabled    (o_irq_enabled),
        .o_rom_offset     (o_rom_offset),
        .o_window_hit     (o_window_hit),
        .o_nametable_map  (o_nametable_map),
        .o_counter_value  (o_counter_value)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------------------------
    // mirror of the mapper state, zero like the block after reset
    // ---------------------------------------------------------------------------------
    logic [DataW-1:0]   pat_banks [NumPat];
    logic [DataW-1:0]   prg_bank = '0;
    t_mirror            mirror = MIRROR_VERT;
    logic [CntW-1:0]    reload = '0;
    logic [CntW:0]      down_cnt = '0;
    logic               cnt_en = 1'b0;
    logic               irq_pend = 1'b0;

    t_mapper_out        mapper_out_q [$];

    int                 send_idle_pct = 0;
    int                 out_stall_pct = 0;
    int                 sent_reqs = 0;
    int                 func_count [4] = '{0, 0, 0, 0};
    int                 underflows = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    initial begin
        foreach (pat_banks[i]) begin
            pat_banks[i] = '0;
        end
    end

    // applies one request to the mirrored state and returns what the block should answer
    function automatic t_mapper_out mapper_next(input t_func f, input logic [AddrW-1:0] a,
                                                input logic [DataW-1:0] d,
                                                input logic [CycW-1:0] c);
        t_mapper_out r;
        logic [DataW-1:0] bank;
        r = '0;
        case (f)
            FUNC_WRITE: begin
                if (a >= REG_BASE) begin
                    if (a[3:0] <= REG_PAT_LAST) begin
                        pat_banks[a[2:0]] = d;
                    end else begin
                        case (a[3:0])
                            REG_PRG_BANK: prg_bank = d;
                            REG_MIRROR:   mirror = t_mirror'(d[1:0]);
                            REG_IRQ_CTRL: begin
                                // ack the irq and restart from the latch
                                irq_pend = 1'b0;
                                cnt_en   = d[0];
                                down_cnt = {1'b0, reload};
                            end
                            REG_LATCH_LO: reload[7:0] = d;
                            REG_LATCH_HI: reload[15:8] = d;
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_TICK: begin
                if (cnt_en) begin
                    if (17'(c) > down_cnt) begin
                        // would go below zero: wrap, stop and raise the line
                        down_cnt = {1'b0, CNT_WRAP};
                        cnt_en   = 1'b0;
                        irq_pend = 1'b1;
                        underflows++;
                    end else begin
                        down_cnt = down_cnt - 17'(c);
                    end
                end
            end
            FUNC_PAT_XLATE: begin
                if (a < PAT_LIMIT) begin
                    bank     = pat_banks[a[12:10]] & BankMask;
                    r.offset = OffW'({bank, a[9:0]});
                    r.hit    = 1'b1;
                end
            end
            default: begin
                if (a >= PRG_WIN_LO && a <= PRG_WIN_HI) begin
                    bank     = prg_bank & BankMask;
                    r.offset = OffW'({bank, a[13:0]});
                    r.hit    = 1'b1;
                end
            end
        endcase
        case (mirror)
            MIRROR_VERT:  r.nt_map = 4'hA;
            MIRROR_HORZ:  r.nt_map = 4'hC;
            MIRROR_ONE_A: r.nt_map = 4'h0;
            default:      r.nt_map = 4'hF;
        endcase
        r.irq     = irq_pend;
        r.enabled = cnt_en;
        r.counter = down_cnt[CntW-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------------------
    // presents one request after a random gap and returns at the edge that takes it
    task automatic send_request(input t_func f, input logic [AddrW-1:0] a,
                                input logic [DataW-1:0] d, input logic [CycW-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_func           <= f;
        i_address        <= a;
        i_write_data     <= d;
        i_elapsed_cycles <= c;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent_reqs++;
        func_count[f]++;
        mapper_out_q.push_back(mapper_next(f, a, d, c));
    endtask

    task automatic write_reg(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
        send_request(FUNC_WRITE, a, d, CycW'($urandom));
    endtask

    // latch load, enable, then a run of ticks: the most direct way to reach an underflow
    task automatic send_irq_sequence();
        int n;
        n = $urandom_range(8, 3);
        write_reg(REG_BASE | AddrW'(REG_LATCH_LO), DataW'($urandom));
        write_reg((AddrW'($urandom_range(16'hFFF0, REG_BASE)) & 16'hFFF0)
                  | AddrW'(REG_LATCH_HI),
                  ($urandom_range(9) < 7) ? '0 : DataW'($urandom));
        write_reg((AddrW'($urandom_range(16'hFFF0, REG_BASE)) & 16'hFFF0)
                  | AddrW'(REG_IRQ_CTRL),
                  DataW'($urandom) | 8'h01);
        repeat (n) begin
            send_request(FUNC_TICK, AddrW'($urandom), DataW'($urandom),
                         ($urandom_range(1)) ? CycW'($urandom_range(40)) : CycW'($urandom));
        end
    endtask

    task automatic send_random_request();
        int pick;
        int sel;
        logic [AddrW-1:0] a;
        logic [DataW-1:0] d;
        logic [CycW-1:0] c;
        t_func f;
        pick = $urandom_range(99);
        a = AddrW'($urandom);
        d = DataW'($urandom);
        c = CycW'($urandom);
        if (pick < 5) begin
            // bus write below the register window
            f = FUNC_WRITE;
            a = AddrW'($urandom_range(REG_BASE - 1, 0));
        end else if (pick < 40) begin
            f = FUNC_WRITE;
            a = AddrW'($urandom_range(16'hFFFF, REG_BASE));
            sel = $urandom_range(99);
            if (sel < 40) begin
                a[3:0] = 4'($urandom_range(REG_PAT_LAST));
            end else if (sel < 50) begin
                a[3:0] = REG_PRG_BANK;
            end else if (sel < 60) begin
                a[3:0] = REG_MIRROR;
            end else if (sel < 72) begin
                a[3:0] = REG_IRQ_CTRL;
                d[0] = ($urandom_range(3) != 0);
            end else if (sel < 84) begin
                a[3:0] = REG_LATCH_LO;
            end else if (sel < 94) begin
                a[3:0] = REG_LATCH_HI;
                // keep the reload mostly short so ticks reach the underflow
                if ($urandom_range(9) < 6) begin
                    d = '0;
                end
            end else begin
                a[3:0] = 4'($urandom_range(15, REG_NOP_FIRST));
            end
        end else if (pick < 65) begin
            f = FUNC_TICK;
            if ($urandom_range(1)) begin
                c = CycW'($urandom_range(16));
            end
        end else if (pick < 83) begin
            f = FUNC_PAT_XLATE;
            if ($urandom_range(99) < 85) begin
                a = AddrW'($urandom_range(PAT_LIMIT - 1));
            end
        end else begin
            f = FUNC_PRG_XLATE;
            if ($urandom_range(99) < 85) begin
                a = AddrW'($urandom_range(PRG_WIN_HI, PRG_WIN_LO));
            end
        end
        send_request(f, a, d, c);
    endtask

    task automatic run_random_phase(input int n, input int gap_pct, input int stall_pct);
        int start;
        send_idle_pct = gap_pct;
        out_stall_pct = stall_pct;
        start = sent_reqs;
        while (sent_reqs - start < n) begin
            if ($urandom_range(9) == 0) begin
                send_irq_sequence();
            end else begin
                send_random_request();
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // result side: random stall, field by field check
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        // keep the log short when something is badly broken
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_mapper_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mapper_out_q.size() == 0) begin
                report_mismatch("result with no request pending", 32'(o_rom_offset), '0);
            end else begin
                want = mapper_out_q.pop_front();
                results_seen++;
                if (o_irq_line !== want.irq) begin
                    report_mismatch("irq_line", 32'(o_irq_line), 32'(want.irq));
                end
                if (o_irq_enabled !== want.enabled) begin
                    report_mismatch("irq_enabled", 32'(o_irq_enabled), 32'(want.enabled));
                end
                if (o_rom_offset !== want.offset) begin
                    report_mismatch("rom_offset", 32'(o_rom_offset), 32'(want.offset));
                end
                if (o_window_hit !== want.hit) begin
                    report_mismatch("window_hit", 32'(o_window_hit), 32'(want.hit));
                end
                if (o_nametable_map !== want.nt_map) begin
                    report_mismatch("nametable_map", 32'(o_nametable_map),
                                    32'(want.nt_map));
                end
                if (o_counter_value !== want.counter) begin
                    report_mismatch("counter_value", 32'(o_counter_value),
                                    32'(want.counter));
                end
            end
        end
    end

    // hang detector: counts cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HangLimit) begin
                $display("timeout: no handshake for %0d cycles", HangLimit);
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------------------------
    // fresh state: zero banks, vertical mirroring, a tick while the counter is off
    task automatic test_reset_state();
        send_request(FUNC_PAT_XLATE, 16'h1FFF, 8'hFF, 8'hFF);
        send_request(FUNC_PRG_XLATE, PRG_WIN_LO, 8'h00, 8'h00);
        send_request(FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    // bank registers at both ends of the window, writes that must be dropped, window edges
    task automatic test_bank_translate();
        write_reg(REG_BASE, 8'hFF);
        write_reg(16'hFFF7, 8'h80);
        write_reg(REG_BASE | AddrW'(REG_PRG_BANK), 8'hFF);
        write_reg(16'h5FF8, 8'h00);
        write_reg(REG_BASE | AddrW'(REG_NOP_FIRST), 8'h12);
        send_request(FUNC_PAT_XLATE, 16'h0000, 8'h00, 8'h00);
        send_request(FUNC_PAT_XLATE, 16'h03FF, 8'hFF, 8'hFF);
        send_request(FUNC_PAT_XLATE, 16'h1FFF, 8'h00, 8'h00);
        send_request(FUNC_PAT_XLATE, PAT_LIMIT, 8'hFF, 8'hFF);
        send_request(FUNC_PRG_XLATE, PRG_WIN_LO - 1, 8'h00, 8'h00);
        send_request(FUNC_PRG_XLATE, PRG_WIN_HI, 8'hFF, 8'hFF);
        send_request(FUNC_PRG_XLATE, PRG_WIN_HI + 1, 8'h00, 8'h00);
    endtask

    // only the low two bits of the data select the mode
    task automatic test_mirroring();
        write_reg(16'hFFF9, 8'hFC | 8'(MIRROR_ONE_B));
        write_reg(REG_BASE | AddrW'(REG_MIRROR), 8'(MIRROR_HORZ));
        write_reg(REG_BASE | AddrW'(REG_MIRROR), 8'(MIRROR_ONE_A));
    endtask

    // zero tick, count exactly to zero, underflow by one, tick while stopped, ack
    task automatic test_irq_counter();
        write_reg(REG_BASE | AddrW'(REG_LATCH_LO), 8'h05);
        write_reg(REG_BASE | AddrW'(REG_LATCH_HI), 8'h00);
        write_reg(REG_BASE | AddrW'(REG_IRQ_CTRL), 8'h01);
        send_request(FUNC_TICK, 16'h0000, 8'h00, 8'd0);
        send_request(FUNC_TICK, 16'h0000, 8'h00, 8'd5);
        send_request(FUNC_TICK, 16'h0000, 8'h00, 8'd1);
        send_request(FUNC_TICK, 16'h0000, 8'h00, 8'd255);
        write_reg(REG_BASE | AddrW'(REG_IRQ_CTRL), 8'hFE);
    endtask

    // random traffic under each flow control pattern
    task automatic test_no_idling();
        run_random_phase(125, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(125, 88, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(125, 0, 88);
    endtask

    task automatic test_both_idle();
        run_random_phase(125, 13, 13);
    endtask

    // ---------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_bank_translate();
        test_mirroring();
        test_irq_counter();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        // drain: everything sent must come back, then a short quiet window
        i_in_valid <= 1'b0;
        out_stall_pct = 13;
        while (mapper_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("sent %0d writes, %0d ticks, %0d pattern and %0d program translates",
                 func_count[FUNC_WRITE], func_count[FUNC_TICK],
                 func_count[FUNC_PAT_XLATE], func_count[FUNC_PRG_XLATE]);
        $display("checked %0d results over four flow control phases, %0d counter wraps",
                 results_seen, underflows);
        if (mismatches == 0 && mapper_out_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[bank_switch_irq_mapper.f]
+incdir+hw/rtl
hw/rtl/bsim_pkg.sv
hw/rtl/bank_switch_irq_mapper.sv
hw/rtl/bsim_checker.sv
tb/testbench.sv
